### rtl/core/mbrs_pkg.sv
// shared types, codes and crc helper for the modbus rtu holding register slave
`timescale 1ns / 1ps
package mbrs_pkg;

    localparam int NUM_REGS_DEF    = 21;
    localparam int FRAME_DEPTH_DEF = 256;
    localparam int MASK_W          = 21;
    localparam int CFG_W           = 21;
    localparam int LEN_W           = 6;

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [7:0]  BCAST     = 8'd255;
    localparam logic [7:0]  EXC_FLAG  = 8'h80;

    localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_GAP_TICKS   = 2'd1;
    localparam logic [1:0] CFG_WR_MASK     = 2'd2;

    localparam logic [7:0] FC_READ_DISC   = 8'd2;
    localparam logic [7:0] FC_READ_HOLD   = 8'd3;
    localparam logic [7:0] FC_WRITE_ONE   = 8'd6;
    localparam logic [7:0] FC_WRITE_MULTI = 8'd16;

    localparam logic [1:0] EXC_ILLEGAL_FUNC  = 2'd1;
    localparam logic [1:0] EXC_ILLEGAL_ADDR  = 2'd2;
    localparam logic [1:0] EXC_ILLEGAL_VALUE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CHECK,
        ST_WR_HI,
        ST_WR_LO,
        ST_WR_DO,
        ST_EM_PREP,
        ST_EM_LOAD,
        ST_EM_WAIT,
        ST_DONE
    } state_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'd0, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### rtl/core/mbrs_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mbrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/modbus_rtu_slave_holding_regs_unit.sv
// modbus rtu slave with a bank of holding registers
//
// input channel (s_): one transaction is either a received byte (opcode 0) or a
// timer tick (opcode 1). bytes with a parity error are dropped. every byte
// clears the silence timer; a tick after more than gap_ticks of silence with
// at least two bytes buffered closes the frame.
// a byte or a tick that closes nothing leaves s_ready high.
// closing a frame walks the frame buffer ram one byte per cycle for the crc;
// a write-multiple request (function 16) then steps through WR_HI, WR_LO and
// WR_DO for each register (frame buffer read port), and each reply byte passes
// EM_PREP, EM_LOAD and EM_WAIT, where it waits for m_ready. s_ready is low from
// the closing tick until the return to idle after the reply or a dropped frame.
// result channel (m_): one transaction per reply byte, m_last on the crc high
// byte. a stalled receiver simply holds the byte in the output register.
// reset (aresetn low, synchronous) loads the register defaults, empties the
// frame and clears all holding registers at once via per-register valid bits.
// configuration writes are taken at any edge with cfg_wr_en high, except in reset.
`timescale 1ns / 1ps
module modbus_rtu_slave_holding_regs_unit #(
    parameter int NUM_REGS    = mbrs_pkg::NUM_REGS_DEF,
    parameter int FRAME_DEPTH = mbrs_pkg::FRAME_DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [mbrs_pkg::CFG_W-1:0] cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_opcode,
    input  logic [7:0]               s_rx_byte,
    input  logic                     s_parity_error,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [7:0]               m_tx_byte,
    output logic                     m_last
);

    import mbrs_pkg::*;

    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    state_t state_reg, state_next;

    logic [AW-1:0]       cnt_reg, cnt_next;
    logic [15:0]         timer_reg, timer_next;
    logic [7:0]          own_reg;
    logic [15:0]         gap_reg;
    logic [MASK_W-1:0]   mask_reg;
    logic [NUM_REGS-1:0] hv_reg, hv_next;
    logic [AW-1:0]       ra_reg, ra_next;
    logic                issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pidx_reg, pidx_next;
    logic [15:0]         crc_reg, crc_next;
    logic [7:0]          b_reg [6];
    logic [7:0]          b_next [6];
    logic [7:0]          c0_reg, c0_next, c1_reg, c1_next;
    logic                exc_reg, exc_next;
    logic [1:0]          code_reg, code_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [4:0]          m_reg, m_next;
    logic                oob_reg, oob_next;
    logic [7:0]          hi_reg, hi_next;
    logic                mv_reg, mv_next;
    logic [7:0]          mtx_reg, mtx_next;
    logic                mlast_reg, mlast_next;
    logic                hrv_reg;

    logic                fb_we;
    logic [AW-1:0]       fb_waddr, fb_raddr;
    logic [7:0]          fb_wdata, fb_rdata;
    logic                hr_we;
    logic [RW-1:0]       hr_waddr, hr_raddr;
    logic [15:0]         hr_wdata, hr_rdata;

    logic [15:0]         start_w, qty_w;
    logic [4:0]          sidx;
    logic [LEN_W-1:0]    kk;

    assign start_w = {b_reg[2], b_reg[3]};
    assign qty_w   = {b_reg[4], b_reg[5]};
    assign sidx    = start_w[4:0] + m_reg;
    assign kk      = k_reg - LEN_W'(3);

    mbrs_ram #(.WIDTH(8), .DEPTH(FRAME_DEPTH)) u_fbuf (
        .aclk  (aclk),
        .we    (fb_we),
        .waddr (fb_waddr),
        .wdata (fb_wdata),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    mbrs_ram #(.WIDTH(16), .DEPTH(NUM_REGS)) u_hregs (
        .aclk  (aclk),
        .we    (hr_we),
        .waddr (hr_waddr),
        .wdata (hr_wdata),
        .raddr (hr_raddr),
        .rdata (hr_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = mv_reg;
    assign m_tx_byte = mtx_reg;
    assign m_last    = mlast_reg;

    // next state
    always_comb begin
        logic ok;
        ok = (b_reg[0] != 8'd0) && ((b_reg[0] == own_reg) || (b_reg[0] == BCAST))
             && (32'(cnt_reg) > 5) && (c0_reg == crc_reg[7:0]) && (c1_reg == crc_reg[15:8]);
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_opcode && (timer_reg > gap_reg) && (32'(cnt_reg) > 1)) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (pend_reg && (pidx_reg == cnt_reg - AW'(1))) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!ok) begin
                    state_next = ST_DONE;
                end else if (b_reg[1] == FC_WRITE_MULTI && !(32'(start_w) >= NUM_REGS
                             || 32'(start_w) + 32'(qty_w) > NUM_REGS)) begin
                    state_next = ST_WR_HI;
                end else begin
                    state_next = ST_EM_PREP;
                end
            end
            ST_WR_HI: begin
                if (m_reg == qty_w[4:0] || !mask_reg[sidx]) begin
                    state_next = ST_EM_PREP;
                end else begin
                    state_next = ST_WR_LO;
                end
            end
            ST_WR_LO:   state_next = ST_WR_DO;
            ST_WR_DO:   state_next = ST_WR_HI;
            ST_EM_PREP: state_next = ST_EM_LOAD;
            ST_EM_LOAD: state_next = ST_EM_WAIT;
            ST_EM_WAIT: begin
                if (m_ready) begin
                    state_next = mlast_reg ? ST_DONE : ST_EM_PREP;
                end
            end
            ST_DONE:    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [AW-1:0]    cnt_eff;
        logic [5:0]       vidx;
        logic [7:0]       tx;
        logic [15:0]      hval;
        logic             range_bad;
        cnt_eff   = (32'(cnt_reg) > FRAME_DEPTH - 2) ? '0 : cnt_reg;
        vidx      = '0;
        tx        = '0;
        hval      = hrv_reg ? hr_rdata : 16'd0;
        range_bad = (32'(start_w) >= NUM_REGS) || (32'(start_w) + 32'(qty_w) > NUM_REGS);

        cnt_next   = cnt_reg;
        timer_next = timer_reg;
        hv_next    = hv_reg;
        ra_next    = ra_reg;
        issue_next = 1'b0;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        crc_next   = crc_reg;
        for (int i = 0; i < 6; i++) begin
            b_next[i] = b_reg[i];
        end
        c0_next    = c0_reg;
        c1_next    = c1_reg;
        exc_next   = exc_reg;
        code_next  = code_reg;
        len_next   = len_reg;
        k_next     = k_reg;
        m_next     = m_reg;
        oob_next   = oob_reg;
        hi_next    = hi_reg;
        mv_next    = mv_reg;
        mtx_next   = mtx_reg;
        mlast_next = mlast_reg;

        fb_we    = 1'b0;
        fb_waddr = AW'(k_reg);
        fb_wdata = 8'd0;
        fb_raddr = ra_reg;
        hr_we    = 1'b0;
        hr_waddr = RW'(sidx);
        hr_wdata = 16'd0;
        hr_raddr = RW'(start_w[4:0] + 5'(kk[LEN_W-1:1]));

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (!s_opcode) begin
                        timer_next = 16'd0;
                        fb_waddr   = cnt_eff;
                        fb_wdata   = s_rx_byte;
                        fb_we      = !s_parity_error;
                        cnt_next   = s_parity_error ? cnt_eff : cnt_eff + AW'(1);
                    end else if ((timer_reg > gap_reg) && (32'(cnt_reg) > 1)) begin
                        timer_next = CRC_INIT;
                        ra_next    = '0;
                        issue_next = 1'b1;
                        crc_next   = CRC_INIT;
                    end else begin
                        timer_next = timer_reg + 16'd1;
                    end
                end
            end
            ST_SCAN: begin
                if (issue_reg) begin
                    pend_next = 1'b1;
                    pidx_next = ra_reg;
                    if (ra_reg != cnt_reg - AW'(1)) begin
                        issue_next = 1'b1;
                        ra_next    = ra_reg + AW'(1);
                    end
                end
                if (pend_reg) begin
                    if (32'(pidx_reg) < 6) begin
                        b_next[pidx_reg[2:0]] = fb_rdata;
                    end
                    if (32'(pidx_reg) + 2 < 32'(cnt_reg)) begin
                        crc_next = crc_byte(crc_reg, fb_rdata);
                    end
                    if (pidx_reg == cnt_reg - AW'(2)) begin
                        c0_next = fb_rdata;
                    end
                    if (pidx_reg == cnt_reg - AW'(1)) begin
                        c1_next = fb_rdata;
                    end
                end
            end
            ST_CHECK: begin
                crc_next  = CRC_INIT;
                k_next    = '0;
                m_next    = '0;
                exc_next  = 1'b1;
                len_next  = LEN_W'(5);
                code_next = EXC_ILLEGAL_FUNC;
                case (b_reg[1])
                    FC_READ_HOLD: begin
                        if (range_bad) begin
                            code_next = EXC_ILLEGAL_ADDR;
                        end else begin
                            exc_next = 1'b0;
                            len_next = LEN_W'({qty_w[4:0], 1'b0}) + LEN_W'(5);
                        end
                    end
                    FC_WRITE_ONE: begin
                        if (32'(start_w) >= NUM_REGS) begin
                            code_next = EXC_ILLEGAL_ADDR;
                        end else if (!mask_reg[start_w[4:0]]) begin
                            code_next = EXC_ILLEGAL_VALUE;
                        end else begin
                            exc_next = 1'b0;
                            len_next = LEN_W'(8);
                            hr_waddr = RW'(start_w[4:0]);
                            hr_wdata = qty_w;
                            hr_we    = (state_next == ST_EM_PREP);
                            if (hr_we) begin
                                hv_next[RW'(start_w[4:0])] = 1'b1;
                            end
                        end
                    end
                    FC_WRITE_MULTI: begin
                        if (range_bad) begin
                            code_next = EXC_ILLEGAL_ADDR;
                        end else begin
                            exc_next = 1'b0;
                            len_next = LEN_W'(8);
                        end
                    end
                    FC_READ_DISC: code_next = EXC_ILLEGAL_ADDR;
                    default:      code_next = EXC_ILLEGAL_FUNC;
                endcase
            end
            ST_WR_HI: begin
                vidx     = 6'd7 + {m_reg, 1'b0};
                fb_raddr = AW'(vidx);
                oob_next = (32'(vidx) >= FRAME_DEPTH);
                if (m_reg != qty_w[4:0] && !mask_reg[sidx]) begin
                    exc_next  = 1'b1;
                    code_next = EXC_ILLEGAL_VALUE;
                    len_next  = LEN_W'(5);
                end
            end
            ST_WR_LO: begin
                vidx     = 6'd8 + {m_reg, 1'b0};
                fb_raddr = AW'(vidx);
                hi_next  = oob_reg ? 8'd0 : fb_rdata;
                oob_next = (32'(vidx) >= FRAME_DEPTH);
            end
            ST_WR_DO: begin
                hr_we          = 1'b1;
                hr_wdata       = {hi_reg, oob_reg ? 8'd0 : fb_rdata};
                hv_next[RW'(sidx)] = 1'b1;
                m_next         = m_reg + 5'd1;
            end
            ST_EM_LOAD: begin
                if (k_reg == len_reg - LEN_W'(2)) begin
                    tx = crc_reg[7:0];
                end else if (k_reg == len_reg - LEN_W'(1)) begin
                    tx = crc_reg[15:8];
                end else if (exc_reg) begin
                    case (k_reg)
                        LEN_W'(0): tx = b_reg[0];
                        LEN_W'(1): tx = b_reg[1] | EXC_FLAG;
                        default:   tx = {6'd0, code_reg};
                    endcase
                end else if (b_reg[1] == FC_READ_HOLD) begin
                    if (k_reg == LEN_W'(0)) begin
                        tx = b_reg[0];
                    end else if (k_reg == LEN_W'(1)) begin
                        tx = b_reg[1];
                    end else if (k_reg == LEN_W'(2)) begin
                        tx = {qty_w[6:0], 1'b0};
                    end else begin
                        tx = kk[0] ? hval[7:0] : hval[15:8];
                    end
                end else begin
                    tx = b_reg[k_reg[2:0]];
                end
                if (k_reg < len_reg - LEN_W'(2)) begin
                    crc_next = crc_byte(crc_reg, tx);
                end
                fb_we      = (32'(k_reg) < FRAME_DEPTH);
                fb_wdata   = tx;
                mv_next    = 1'b1;
                mtx_next   = tx;
                mlast_next = (k_reg == len_reg - LEN_W'(1));
            end
            ST_EM_WAIT: begin
                if (m_ready) begin
                    mv_next = 1'b0;
                    k_next  = k_reg + LEN_W'(1);
                end
            end
            ST_DONE: begin
                cnt_next   = '0;
                timer_next = CRC_INIT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            timer_reg <= 16'hFFFF;
            own_reg   <= 8'd1;
            gap_reg   <= 16'd3;
            mask_reg  <= '1;
            hv_reg    <= '0;
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            timer_reg <= timer_next;
            hv_reg    <= hv_next;
            issue_reg <= issue_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_OWN_ADDRESS: own_reg  <= cfg_data[7:0];
                    CFG_GAP_TICKS:   gap_reg  <= cfg_data[15:0];
                    CFG_WR_MASK:     mask_reg <= cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ra_reg    <= ra_next;
        pidx_reg  <= pidx_next;
        crc_reg   <= crc_next;
        for (int i = 0; i < 6; i++) begin
            b_reg[i] <= b_next[i];
        end
        c0_reg    <= c0_next;
        c1_reg    <= c1_next;
        exc_reg   <= exc_next;
        code_reg  <= code_next;
        len_reg   <= len_next;
        k_reg     <= k_next;
        m_reg     <= m_next;
        oob_reg   <= oob_next;
        hi_reg    <= hi_next;
        mtx_reg   <= mtx_next;
        mlast_reg <= mlast_next;
        hrv_reg   <= hv_reg[hr_raddr];
    end

endmodule

### tb/testbench.sv
// self-checking testbench for the modbus rtu holding register slave
`timescale 1ns / 1ps
module testbench;
    import mbrs_pkg::*;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       perr;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_byte_t;

    localparam logic [7:0] FC_UNKNOWN = 8'd99;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [20:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_opcode;
    logic [7:0]  s_rx_byte;
    logic        s_parity_error;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_tx_byte;
    logic        m_last;

    modbus_rtu_slave_holding_regs_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_rx_byte(s_rx_byte), .s_parity_error(s_parity_error),
        .m_valid(m_valid), .m_ready(m_ready), .m_tx_byte(m_tx_byte), .m_last(m_last)
    );

    // slave mirror
    logic [7:0]  slv_addr;
    logic [15:0] slv_gap;
    logic [20:0] slv_mask;
    logic [7:0]  slv_buf [0:255];
    logic [8:0]  slv_count;
    logic [15:0] slv_timer;
    logic [15:0] slv_regs [0:20];
    logic [7:0]  txb [0:46];

    rx_item_t    pending_rx[$];
    reply_byte_t reply_q[$];
    int          err_cnt = 0;
    int          replies_seen = 0;
    int          item_total = 0;
    logic [7:0]  frm [0:63];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [15:0] crc_update(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {8'd0, d};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function automatic int set_exc(input logic [1:0] code);
        txb[1] = txb[1] | 8'h80;
        txb[2] = {6'd0, code};
        return 5;
    endfunction

    function automatic void close_and_answer();
        int n, len;
        logic [15:0] crc, v;
        logic [31:0] start, qty;
        logic [7:0] a;
        n = slv_count;
        a = slv_buf[0];
        if (a == 0 || n <= 5 || (a != slv_addr && a != 8'd255)) return;
        crc = 16'hFFFF;
        for (int i = 0; i < n - 2; i++) crc = crc_update(crc, slv_buf[i]);
        if (slv_buf[n-2] != crc[7:0] || slv_buf[n-1] != crc[15:8]) return;
        for (int i = 0; i < 47; i++) txb[i] = (i < 6) ? slv_buf[i] : 8'd0;
        start = {slv_buf[2], slv_buf[3]};
        qty = {slv_buf[4], slv_buf[5]};
        case (slv_buf[1])
            FC_READ_HOLD: begin
                if (start >= 21 || start + qty > 21) begin
                    len = set_exc(EXC_ILLEGAL_ADDR);
                end else begin
                    for (int m = 0; m < qty; m++) begin
                        txb[3+2*m] = slv_regs[start+m][15:8];
                        txb[4+2*m] = slv_regs[start+m][7:0];
                    end
                    txb[2] = 8'(qty * 2);
                    len = qty * 2 + 5;
                end
            end
            FC_WRITE_ONE: begin
                if (start >= 21) len = set_exc(EXC_ILLEGAL_ADDR);
                else if (!slv_mask[start]) len = set_exc(EXC_ILLEGAL_VALUE);
                else begin
                    slv_regs[start] = qty[15:0];
                    len = 8;
                end
            end
            FC_WRITE_MULTI: begin
                if (start >= 21 || start + qty > 21) begin
                    len = set_exc(EXC_ILLEGAL_ADDR);
                end else begin
                    len = 8;
                    for (int m = 0; m < qty; m++) begin
                        v = {slv_buf[7+2*m], slv_buf[8+2*m]};
                        if (!slv_mask[start+m]) begin
                            len = set_exc(EXC_ILLEGAL_VALUE);
                            break;
                        end
                        slv_regs[start+m] = v;
                    end
                end
            end
            FC_READ_DISC: len = set_exc(EXC_ILLEGAL_ADDR);
            default: len = set_exc(EXC_ILLEGAL_FUNC);
        endcase
        crc = 16'hFFFF;
        for (int i = 0; i < len - 2; i++) crc = crc_update(crc, txb[i]);
        txb[len-2] = crc[7:0];
        txb[len-1] = crc[15:8];
        for (int i = 0; i < len; i++) begin
            slv_buf[i] = txb[i];
            reply_q.push_back('{data: txb[i], last: (i == len - 1)});
        end
    endfunction

    function automatic void slave_step(input rx_item_t it);
        logic closing;
        if (!it.op) begin
            slv_timer = 16'd0;
            if (slv_count > 254) slv_count = 9'd0;
            if (!it.perr) begin
                slv_buf[slv_count] = it.data;
                slv_count = slv_count + 9'd1;
            end
        end else begin
            closing = (slv_timer > slv_gap) && (slv_count > 1);
            slv_timer = slv_timer + 16'd1;
            if (closing) begin
                close_and_answer();
                slv_count = 9'd0;
                slv_timer = 16'hFFFF;
            end
        end
    endfunction

    // driver
    int burst_left = 0;
    int gap_left = 0;
    rx_item_t cur;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                slave_step('{op: s_opcode, data: s_rx_byte, perr: s_parity_error});
            if (s_valid && !s_ready) begin
                // hold the offered transaction
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_rx.size() > 0) begin
                cur = pending_rx.pop_front();
                s_opcode <= cur.op;
                s_rx_byte <= cur.data;
                s_parity_error <= cur.perr;
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver
    int hold_cnt = 0;
    bit long_hold_done = 0;
    int pat_mode = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_ready <= 1'b0;
        end else if (!long_hold_done && replies_seen >= 100) begin
            long_hold_done <= 1;
            hold_cnt <= 3000;
            m_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 63) == 0) pat_mode <= $urandom_range(0, 2);
            case (pat_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // monitor
    reply_byte_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            replies_seen <= replies_seen + 1;
            if (reply_q.size() == 0) begin
                $error("unexpected reply transaction tx_byte=%0h", m_tx_byte);
                err_cnt++;
            end else begin
                want = reply_q.pop_front();
                if (m_tx_byte !== want.data) begin
                    $error("tx_byte expected %0h actual %0h", want.data, m_tx_byte);
                    err_cnt++;
                end
                if (m_last !== want.last) begin
                    $error("last expected %0h actual %0h", want.last, m_last);
                    err_cnt++;
                end
            end
        end
    end

    task automatic push_rx(input logic op, input logic [7:0] d, input logic pe);
        pending_rx.push_back('{op: op, data: d, perr: pe});
        item_total++;
    endtask

    task automatic push_ticks(input int k);
        for (int i = 0; i < k; i++) push_rx(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // sends frm[0..n-1] with crc, then enough ticks to close
    task automatic send_frame(input int n, input bit bad_crc, input int perr_pos);
        logic [15:0] crc;
        crc = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            crc = crc_update(crc, frm[i]);
            push_rx(1'b0, frm[i], 1'b0);
            if (i == perr_pos) push_rx(1'b0, 8'($urandom), 1'b1);
        end
        if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
        push_rx(1'b0, crc[7:0], 1'b0);
        push_rx(1'b0, crc[15:8], 1'b0);
        push_ticks(slv_gap + 2 + $urandom_range(0, 2));
    endtask

    task automatic build(input logic [7:0] a, input logic [7:0] fc,
                         input logic [15:0] st, input logic [15:0] q, output int n);
        frm[0] = a; frm[1] = fc;
        frm[2] = st[15:8]; frm[3] = st[7:0];
        frm[4] = q[15:8]; frm[5] = q[7:0];
        n = 6;
        if (fc == FC_WRITE_MULTI && q <= 21) begin
            frm[6] = 8'(q * 2);
            for (int i = 0; i < 2 * q; i++) frm[7+i] = 8'($urandom);
            n = 7 + 2 * q;
        end
    endtask

    task automatic directed_frame(input logic [7:0] a, input logic [7:0] fc,
                                  input logic [15:0] st, input logic [15:0] q);
        int n;
        build(a, fc, st, q, n);
        send_frame(n, 0, -1);
    endtask

    task automatic random_frame();
        int n, r, sel;
        logic [7:0] a, fc;
        logic [15:0] st, q;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // noise: loose bytes, some with parity errors, then ticks
            for (int i = $urandom_range(0, 8); i > 0; i--)
                push_rx(1'b0, 8'($urandom), $urandom_range(0, 3) == 0);
            push_ticks($urandom_range(1, slv_gap + 3));
            return;
        end
        sel = $urandom_range(0, 9);
        a = (sel < 5) ? slv_addr : (sel < 8) ? 8'd255 : (sel == 8) ? 8'd0 : 8'($urandom);
        sel = $urandom_range(0, 19);
        fc = (sel < 6) ? FC_READ_HOLD : (sel < 11) ? FC_WRITE_ONE :
             (sel < 17) ? FC_WRITE_MULTI : (sel == 17) ? FC_READ_DISC : 8'($urandom);
        if ($urandom_range(0, 7) == 0) begin
            st = 16'($urandom); q = 16'($urandom);
        end else begin
            st = 16'($urandom_range(0, 22));
            q = (fc == FC_WRITE_ONE) ? 16'($urandom) :
                16'($urandom_range(0, 21 - (st > 21 ? 21 : st) + 1));
        end
        build(a, fc, st, q, n);
        if ($urandom_range(0, 9) == 0 && n > 1) n = $urandom_range(1, n - 1);
        send_frame(n, $urandom_range(0, 9) == 0,
                   ($urandom_range(0, 19) == 0) ? $urandom_range(0, n - 1) : -1);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [20:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_OWN_ADDRESS: slv_addr = v[7:0];
            CFG_GAP_TICKS:   slv_gap = v[15:0];
            default:         slv_mask = v;
        endcase
    endtask

    task automatic wait_idle();
        do @(posedge aclk); while (pending_rx.size() != 0 || s_valid || reply_q.size() != 0);
        repeat (400) @(posedge aclk);
    endtask

    task automatic random_phase(input int items);
        int goal;
        goal = item_total + items;
        while (item_total < goal) random_frame();
    endtask

    initial begin
        aresetn = 0;
        cfg_wr_en = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_opcode = 0; s_rx_byte = 0; s_parity_error = 0;
        m_ready = 0;
        slv_addr = 1; slv_gap = 3; slv_mask = 21'h1FFFFF;
        for (int i = 0; i < 256; i++) slv_buf[i] = 0;
        for (int i = 0; i < 21; i++) slv_regs[i] = 0;
        slv_count = 0; slv_timer = 16'hFFFF;
        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // prime the frame buffer with an unanswered frame
        push_rx(1'b0, 8'd0, 1'b0);
        for (int i = 1; i < 60; i++) push_rx(1'b0, 8'($urandom), 1'b0);
        push_ticks(6);
        directed_frame(8'd1, FC_WRITE_ONE, 16'd20, 16'hFFFF);
        directed_frame(8'd1, FC_WRITE_ONE, 16'd0, 16'h0000);
        directed_frame(8'd255, FC_WRITE_MULTI, 16'd0, 16'd21);
        directed_frame(8'd1, FC_READ_HOLD, 16'd0, 16'd21);
        directed_frame(8'd1, FC_READ_HOLD, 16'd5, 16'd0);
        directed_frame(8'd1, FC_READ_HOLD, 16'd21, 16'd0);
        directed_frame(8'd1, FC_READ_HOLD, 16'd20, 16'd2);
        directed_frame(8'd1, FC_WRITE_ONE, 16'hFFFF, 16'd1);
        directed_frame(8'd1, FC_WRITE_MULTI, 16'd3, 16'd0);
        directed_frame(8'd1, FC_READ_DISC, 16'd0, 16'd1);
        directed_frame(8'd1, FC_UNKNOWN, 16'd0, 16'd1);
        random_phase(30);
        wait_idle();

        cfg_write(CFG_OWN_ADDRESS, 21'd254);
        cfg_write(CFG_GAP_TICKS, 21'd0);
        cfg_write(CFG_WR_MASK, 21'd0);
        directed_frame(8'd254, FC_WRITE_ONE, 16'd4, 16'h1234);
        directed_frame(8'd254, FC_WRITE_MULTI, 16'd0, 16'd3);
        random_phase(20);
        wait_idle();

        cfg_write(CFG_OWN_ADDRESS, 21'(1 + $urandom_range(0, 253)));
        cfg_write(CFG_GAP_TICKS, 21'($urandom_range(1, 5)));
        cfg_write(CFG_WR_MASK, 21'($urandom));
        random_phase(30);
        wait_idle();

        cfg_write(CFG_OWN_ADDRESS, 21'd1);
        cfg_write(CFG_WR_MASK, 21'h1FFFFF);
        cfg_write(CFG_GAP_TICKS, 21'd65534);
        // four ticks do not close a frame under a gap of 65534 ticks
        for (int i = 0; i < 8; i++) push_rx(1'b0, 8'($urandom), 1'b0);
        push_ticks(4);
        wait_idle();
        cfg_write(CFG_GAP_TICKS, 21'd2);
        random_phase(20);

        wait_idle();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/core/mbrs_pkg.sv
rtl/core/mbrs_ram.sv
rtl/core/modbus_rtu_slave_holding_regs_unit.sv
tb/testbench.sv
